### design/clpp_pkg.sv
// Shared types, constants and helper functions of the command line parser.
package clpp_pkg;

	localparam int LINE_MAX   = 128;
	localparam int MAX_TOKENS = 10;
	localparam int CMD_MAX    = 32;

	localparam int AW = $clog2(LINE_MAX);
	localparam int PW = AW + 1;
	localparam int TW = $clog2(MAX_TOKENS + 1);
	localparam int IW = $clog2(MAX_TOKENS);
	localparam int SW = $clog2(CMD_MAX);

	localparam logic [1:0] KIND_HDR   = 2'd0;
	localparam logic [1:0] KIND_CHAR  = 2'd1;
	localparam logic [1:0] KIND_PARAM = 2'd2;

	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_LX    = 8'd120;
	localparam logic [7:0] CH_UX    = 8'd88;

	localparam logic [31:0] OFS_DEC   = 32'd48;
	localparam logic [31:0] OFS_UPPER = 32'd55;
	localparam logic [31:0] OFS_LOWER = 32'd87;

	typedef enum logic [1:0] {
		CL_OTHER,
		CL_SPACE,
		CL_LETTER,
		CL_DIGIT
	} cls_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_of_line;
	} in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] value;
		logic [4:0]  cmd_length;
		logic        overflow;
		logic        last;
	} out_t;

	typedef struct packed {
		logic load_en;
		logic scan_init;
		logic scan_en;
		logic span_calc;
		logic hdr_emit;
		logic crd;
		logic cemit;
		logic ninit;
		logic nrd;
		logic nacc;
		logic nemit;
		logic fin;
	} ctrl_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
		logic span_zero;
		logic tc_gt1;
		logic k_last;
		logic t_last;
		logic k_le_final;
	} stat_t;

	function automatic cls_t classify(input logic [7:0] b);
		cls_t c;
		if (b == CH_SPACE) begin
			c = CL_SPACE;
		end else if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)) begin
			c = CL_LETTER;
		end else if (b >= 8'd48 && b <= 8'd57) begin
			c = CL_DIGIT;
		end else begin
			c = CL_OTHER;
		end
		return c;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'd48 && b <= 8'd57) || (b >= 8'd97 && b <= 8'd102)
			|| (b >= 8'd65 && b <= 8'd70);
	endfunction

endpackage

### design/clpp_ram.sv
// Generic single-port RAM with registered read data.
module clpp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### design/clpp_ctrl.sv
// Controller state machine sequencing load, scan and result emission.
module clpp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            line_valid,
	input  logic            eol,
	input  clpp_pkg::stat_t stat,
	output logic            line_ready,
	output clpp_pkg::ctrl_t ctrl
);

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SCAN,
		ST_SPAN,
		ST_HDR,
		ST_CRD,
		ST_CWAIT,
		ST_NINIT,
		ST_NCHK,
		ST_NACC,
		ST_NOUT,
		ST_FIN
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign line_ready = (state_q == ST_LOAD);

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			ST_LOAD: begin
				if (line_valid) begin
					ctrl.load_en = 1'b1;
					if (eol) begin
						ctrl.scan_init = 1'b1;
						state_d        = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				ctrl.scan_en = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: begin
				ctrl.span_calc = 1'b1;
				state_d        = ST_HDR;
			end
			ST_HDR: begin
				if (stat.out_free) begin
					ctrl.hdr_emit = 1'b1;
					if (!stat.span_zero) begin
						state_d = ST_CRD;
					end else if (stat.tc_gt1) begin
						state_d = ST_NINIT;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_CRD: begin
				ctrl.crd = 1'b1;
				state_d  = ST_CWAIT;
			end
			ST_CWAIT: begin
				ctrl.crd = 1'b1;
				if (stat.out_free) begin
					ctrl.cemit = 1'b1;
					if (!stat.k_last) begin
						state_d = ST_CRD;
					end else if (stat.tc_gt1) begin
						state_d = ST_NINIT;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_NINIT: begin
				ctrl.ninit = 1'b1;
				state_d    = ST_NCHK;
			end
			ST_NCHK: begin
				if (stat.k_le_final) begin
					ctrl.nrd = 1'b1;
					state_d  = ST_NACC;
				end else begin
					state_d = ST_NOUT;
				end
			end
			ST_NACC: begin
				ctrl.nacc = 1'b1;
				state_d   = ST_NCHK;
			end
			ST_NOUT: begin
				if (stat.out_free) begin
					ctrl.nemit = 1'b1;
					state_d    = stat.t_last ? ST_FIN : ST_NINIT;
				end
			end
			ST_FIN: begin
				ctrl.fin = 1'b1;
				state_d  = ST_LOAD;
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

endmodule

### design/clpp_dp.sv
// Datapath: line store, scan registers, number accumulator and output register.
module clpp_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  clpp_pkg::ctrl_t  ctrl,
	input  clpp_pkg::in_t    line_word,
	input  logic             result_ready,
	output clpp_pkg::stat_t  stat,
	output logic             result_valid,
	output clpp_pkg::out_t   result_word
);

	logic [clpp_pkg::PW-1:0] len_q;
	logic                    flag_q;
	logic [clpp_pkg::TW-1:0] tc_q;
	logic [clpp_pkg::PW-1:0] cf_q;
	logic [clpp_pkg::PW-1:0] cl_q;
	logic                    drop_q;
	logic [clpp_pkg::PW-1:0] rd_q;
	logic                    rv_s1;
	logic [clpp_pkg::PW-1:0] ra_s1;
	logic                    out_valid_q;
	logic [7:0]              cur_q;
	logic [7:0]              prev_q;
	logic                    base_q  [clpp_pkg::MAX_TOKENS];
	logic [clpp_pkg::PW-1:0] first_q [clpp_pkg::MAX_TOKENS];
	logic [clpp_pkg::PW-1:0] final_q [clpp_pkg::MAX_TOKENS];
	logic [clpp_pkg::SW-1:0] span_q;
	logic [clpp_pkg::PW-1:0] k_q;
	logic [clpp_pkg::TW-1:0] t_q;
	logic [31:0]             acc_q;
	logic                    beyond_s1;
	clpp_pkg::out_t          out_q;

	logic                    ram_we;
	logic [clpp_pkg::AW-1:0] ram_addr;
	logic [7:0]              ram_rdata;
	logic [clpp_pkg::PW-1:0] cpos;
	logic [clpp_pkg::PW-1:0] rpos;
	logic [7:0]              rbyte;
	logic [clpp_pkg::IW-1:0] t_idx;
	logic                    proc;
	logic [clpp_pkg::PW-1:0] pos_i;

	logic [clpp_pkg::TW-1:0] tc_v;
	logic [clpp_pkg::PW-1:0] cf_v;
	logic [clpp_pkg::PW-1:0] cl_v;
	logic                    drop_v;
	logic                    flag_v;
	logic                    new_we;
	logic                    new_hex;
	logic [clpp_pkg::PW-1:0] new_pos;
	logic [clpp_pkg::IW-1:0] new_idx;
	logic                    fin_we;
	logic [clpp_pkg::IW-1:0] fin_idx;
	clpp_pkg::cls_t          cls_c;
	clpp_pkg::cls_t          cls_p;

	logic [clpp_pkg::PW-1:0] diff;
	logic [31:0]             digit;
	logic [31:0]             acc_n;
	logic                    hdr_last;
	logic                    char_last;

	assign cpos  = cf_q + k_q;
	assign rpos  = ctrl.crd ? cpos : k_q;
	assign rbyte = beyond_s1 ? 8'd0 : ram_rdata;
	assign t_idx = clpp_pkg::IW'(t_q);

	assign ram_we = ctrl.load_en && (len_q < clpp_pkg::PW'(clpp_pkg::LINE_MAX));

	always_comb begin
		if (ctrl.load_en) begin
			ram_addr = len_q[clpp_pkg::AW-1:0];
		end else if (ctrl.scan_en) begin
			ram_addr = rd_q[clpp_pkg::AW-1:0];
		end else begin
			ram_addr = rpos[clpp_pkg::AW-1:0];
		end
	end

	clpp_ram #(
		.WIDTH(8),
		.DEPTH(clpp_pkg::LINE_MAX)
	) u_line_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(line_word.ch),
		.rdata(ram_rdata)
	);

	// One scan step examines the byte at position pos_i with the next byte as lookahead.
	assign proc  = ctrl.scan_en && rv_s1 && (ra_s1 != '0);
	assign pos_i = ra_s1 - clpp_pkg::PW'(1);

	always_comb begin
		tc_v    = tc_q;
		cf_v    = cf_q;
		cl_v    = cl_q;
		drop_v  = drop_q;
		flag_v  = flag_q;
		new_we  = 1'b0;
		new_hex = 1'b0;
		new_pos = pos_i;
		new_idx = clpp_pkg::IW'(tc_q);
		fin_we  = 1'b0;
		fin_idx = '0;
		cls_c   = clpp_pkg::classify(cur_q);
		cls_p   = clpp_pkg::classify(prev_q);
		if (proc) begin
			if (cls_p == clpp_pkg::CL_SPACE && cls_c == clpp_pkg::CL_LETTER) begin
				tc_v   = clpp_pkg::TW'(1);
				cf_v   = pos_i;
				cl_v   = pos_i;
				drop_v = 1'b0;
			end
			if (cls_p == clpp_pkg::CL_LETTER && cls_c == clpp_pkg::CL_LETTER
				&& tc_v == clpp_pkg::TW'(1)) begin
				cl_v = pos_i;
			end
			if (cls_p == clpp_pkg::CL_SPACE && cls_c == clpp_pkg::CL_DIGIT && tc_v != '0) begin
				if (tc_v < clpp_pkg::TW'(clpp_pkg::MAX_TOKENS)) begin
					new_we  = 1'b1;
					new_idx = clpp_pkg::IW'(tc_v);
					new_hex = (cur_q == clpp_pkg::CH_ZERO)
						&& (ram_rdata == clpp_pkg::CH_LX || ram_rdata == clpp_pkg::CH_UX);
					new_pos = new_hex ? pos_i + clpp_pkg::PW'(2) : pos_i;
					tc_v    = tc_v + clpp_pkg::TW'(1);
				end else begin
					flag_v = 1'b1;
					drop_v = 1'b1;
				end
			end
			if (tc_v > clpp_pkg::TW'(1) && !drop_v && clpp_pkg::is_hex(prev_q)
				&& clpp_pkg::is_hex(cur_q)) begin
				fin_we  = 1'b1;
				fin_idx = clpp_pkg::IW'(tc_v - clpp_pkg::TW'(1));
			end
		end
	end

	assign diff = cl_q - cf_q + clpp_pkg::PW'(1);

	always_comb begin
		if (base_q[t_idx]) begin
			if (rbyte >= 8'd48 && rbyte <= 8'd57) begin
				digit = 32'(rbyte) - clpp_pkg::OFS_DEC;
			end else if (rbyte >= 8'd65 && rbyte <= 8'd70) begin
				digit = 32'(rbyte) - clpp_pkg::OFS_UPPER;
			end else begin
				digit = 32'(rbyte) - clpp_pkg::OFS_LOWER;
			end
			acc_n = {acc_q[27:0], 4'd0} + digit;
		end else begin
			digit = 32'(rbyte) - clpp_pkg::OFS_DEC;
			acc_n = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} + digit;
		end
	end

	assign hdr_last  = (span_q == '0) && (tc_q <= clpp_pkg::TW'(1));
	assign char_last = stat.k_last && (tc_q <= clpp_pkg::TW'(1));

	assign stat.scan_done  = (rd_q >= len_q) && !rv_s1;
	assign stat.out_free   = !out_valid_q || result_ready;
	assign stat.span_zero  = (span_q == '0);
	assign stat.tc_gt1     = (tc_q > clpp_pkg::TW'(1));
	assign stat.k_last     = (int'(k_q) + 1 >= int'(span_q));
	assign stat.t_last     = (int'(t_q) + 1 >= int'(tc_q));
	assign stat.k_le_final = (k_q <= final_q[t_idx]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			flag_q      <= 1'b0;
			tc_q        <= '0;
			cf_q        <= '0;
			cl_q        <= '0;
			drop_q      <= 1'b0;
			rd_q        <= '0;
			rv_s1       <= 1'b0;
			ra_s1       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load_en) begin
				if (ram_we) begin
					len_q <= len_q + clpp_pkg::PW'(1);
				end else begin
					flag_q <= 1'b1;
				end
			end
			if (ctrl.scan_init) begin
				rd_q   <= '0;
				rv_s1  <= 1'b0;
				tc_q   <= '0;
				drop_q <= 1'b0;
			end
			if (ctrl.scan_en) begin
				rv_s1 <= (rd_q < len_q);
				ra_s1 <= rd_q;
				if (rd_q < len_q) begin
					rd_q <= rd_q + clpp_pkg::PW'(1);
				end
				if (proc) begin
					tc_q   <= tc_v;
					cf_q   <= cf_v;
					cl_q   <= cl_v;
					drop_q <= drop_v;
					flag_q <= flag_v;
				end
			end
			if (ctrl.span_calc && tc_q != '0 && int'(diff) > clpp_pkg::CMD_MAX - 1) begin
				flag_q <= 1'b1;
			end
			if (ctrl.hdr_emit || ctrl.cemit || ctrl.nemit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.fin) begin
				len_q  <= '0;
				flag_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		beyond_s1 <= (rpos >= len_q);
		if (ctrl.scan_init) begin
			prev_q <= clpp_pkg::CH_SPACE;
		end
		if (ctrl.scan_en && rv_s1) begin
			cur_q <= ram_rdata;
			if (proc) begin
				prev_q <= cur_q;
			end
		end
		if (new_we) begin
			base_q[new_idx]  <= new_hex;
			first_q[new_idx] <= new_pos;
			final_q[new_idx] <= new_pos;
		end
		if (fin_we) begin
			final_q[fin_idx] <= pos_i;
		end
		if (ctrl.span_calc) begin
			if (tc_q == '0) begin
				span_q <= '0;
			end else if (int'(diff) > clpp_pkg::CMD_MAX - 1) begin
				span_q <= clpp_pkg::SW'(clpp_pkg::CMD_MAX - 1);
			end else begin
				span_q <= clpp_pkg::SW'(diff);
			end
		end
		if (ctrl.hdr_emit) begin
			k_q <= '0;
			t_q <= clpp_pkg::TW'(1);
		end
		if (ctrl.cemit || ctrl.nrd) begin
			k_q <= k_q + clpp_pkg::PW'(1);
		end
		if (ctrl.ninit) begin
			k_q   <= first_q[t_idx];
			acc_q <= '0;
		end
		if (ctrl.nacc) begin
			acc_q <= acc_n;
		end
		if (ctrl.nemit) begin
			t_q <= t_q + clpp_pkg::TW'(1);
		end
		if (ctrl.hdr_emit) begin
			out_q.kind  <= clpp_pkg::KIND_HDR;
			out_q.value <= 32'(tc_q);
			out_q.last  <= hdr_last;
		end else if (ctrl.cemit) begin
			out_q.kind  <= clpp_pkg::KIND_CHAR;
			out_q.value <= 32'(rbyte);
			out_q.last  <= char_last;
		end else if (ctrl.nemit) begin
			out_q.kind  <= clpp_pkg::KIND_PARAM;
			out_q.value <= acc_q;
			out_q.last  <= stat.t_last;
		end
		if (ctrl.hdr_emit || ctrl.cemit || ctrl.nemit) begin
			out_q.cmd_length <= 5'(span_q);
			out_q.overflow   <= flag_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result_word  = out_q;

endmodule

### design/command_line_param_parser.sv
// Top level of the command line parser: controller, datapath and checks.
// While loading, each valid byte word is taken; the end-of-line word starts the scan.
// The scan reads the line store once, one byte per cycle.
// Then a span state sizes the command; the header and each command character are
// emitted when the output is free. Numbers accumulate byte by byte; ST_FIN ends a line.
// Reset clears the controller state, line length, flags and output valid; the line store needs no clearing pass.
module command_line_param_parser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           line_valid,
	output logic           line_ready,
	input  clpp_pkg::in_t  line_word,
	output logic           result_valid,
	input  logic           result_ready,
	output clpp_pkg::out_t result_word
);

	clpp_pkg::ctrl_t ctrl;
	clpp_pkg::stat_t stat;

	clpp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.line_valid(line_valid),
		.eol       (line_word.end_of_line),
		.stat      (stat),
		.line_ready(line_ready),
		.ctrl      (ctrl)
	);

	clpp_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.line_word   (line_word),
		.result_ready(result_ready),
		.stat        (stat),
		.result_valid(result_valid),
		.result_word (result_word)
	);

	a_emit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.hdr_emit, ctrl.cemit, ctrl.nemit}))
		else $error("several result words emitted in one cycle");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.hdr_emit || ctrl.cemit || ctrl.nemit) |-> stat.out_free)
		else $error("result word emitted over a pending word");

	a_fin_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.fin |=> line_ready)
		else $error("parser not ready for a new line after finishing");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.scan_en |-> !line_ready)
		else $error("line accepted during scan");

endmodule

### dv/command_line_param_parser_checker.sv
// Line tokenizer predictor and result word checker for the command line parser bench.
`timescale 1ns / 1ps
module command_line_param_parser_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           line_valid,
	input  logic           line_ready,
	input  clpp_pkg::in_t  line_word,
	input  logic           result_valid,
	input  logic           result_ready,
	input  clpp_pkg::out_t result_word,
	output int             errors,
	output int             pending,
	output int             words_checked
);

	logic [7:0]     text[clpp_pkg::LINE_MAX];
	int unsigned    text_len;
	bit             limit_hit;
	int unsigned    tokens, cmd_lo, cmd_hi;
	bit             num_hex[clpp_pkg::MAX_TOKENS];
	int unsigned    num_lo[clpp_pkg::MAX_TOKENS], num_hi[clpp_pkg::MAX_TOKENS];
	clpp_pkg::out_t expected_words[$];

	assign pending = expected_words.size();

	function automatic logic [7:0] text_at(int unsigned idx);
		return (idx >= text_len) ? 8'd0 : text[idx];
	endfunction

	function automatic clpp_pkg::cls_t char_class(logic [7:0] b);
		if (b == 8'd32) return clpp_pkg::CL_SPACE;
		if ((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122))
			return clpp_pkg::CL_LETTER;
		if (b >= 8'd48 && b <= 8'd57) return clpp_pkg::CL_DIGIT;
		return clpp_pkg::CL_OTHER;
	endfunction

	function automatic bit hex_char(logic [7:0] b);
		return (b >= 8'd48 && b <= 8'd57) || (b >= 8'd97 && b <= 8'd102)
			|| (b >= 8'd65 && b <= 8'd70);
	endfunction

	function automatic logic [31:0] number_of(int unsigned t);
		logic [31:0] acc;
		logic [31:0] b;
		acc = '0;
		for (int unsigned k = num_lo[t]; k <= num_hi[t]; k++) begin
			b = 32'(text_at(k));
			if (!num_hex[t]) acc = acc * 32'd10 + (b - clpp_pkg::OFS_DEC);
			else if (b >= 48 && b <= 57) acc = acc * 32'd16 + (b - clpp_pkg::OFS_DEC);
			else if (b >= 65 && b <= 70) acc = acc * 32'd16 + (b - clpp_pkg::OFS_UPPER);
			else acc = acc * 32'd16 + (b - clpp_pkg::OFS_LOWER);
		end
		return acc;
	endfunction

	task automatic tokenize_line();
		clpp_pkg::cls_t prev, c;
		logic [7:0]     b, nx;
		bit             dropping;
		int unsigned    span;
		clpp_pkg::out_t w;
		prev = clpp_pkg::CL_SPACE;
		dropping = 1'b0;
		span = 0;
		tokens = 0;
		for (int unsigned i = 0; i + 1 < text_len; i++) begin
			b = text[i];
			c = char_class(b);
			if (prev == clpp_pkg::CL_SPACE && c == clpp_pkg::CL_LETTER) begin
				tokens = 1;
				cmd_lo = i;
				cmd_hi = i;
				dropping = 1'b0;
			end
			if (prev == clpp_pkg::CL_LETTER && c == clpp_pkg::CL_LETTER && tokens == 1)
				cmd_hi = i;
			if (prev == clpp_pkg::CL_SPACE && c == clpp_pkg::CL_DIGIT && tokens != 0) begin
				if (tokens < clpp_pkg::MAX_TOKENS) begin
					nx = text_at(i + 1);
					if (b == clpp_pkg::CH_ZERO && (nx == clpp_pkg::CH_LX
						|| nx == clpp_pkg::CH_UX)) begin
						num_hex[tokens] = 1'b1;
						num_lo[tokens] = i + 2;
						num_hi[tokens] = i + 2;
					end else begin
						num_hex[tokens] = 1'b0;
						num_lo[tokens] = i;
						num_hi[tokens] = i;
					end
					tokens++;
				end else begin
					limit_hit = 1'b1;
					dropping = 1'b1;
				end
			end
			if (tokens > 1 && !dropping && i > 0 && hex_char(text[i - 1]) && hex_char(b))
				num_hi[tokens - 1] = i;
			prev = c;
		end
		if (tokens >= 1) begin
			span = cmd_hi - cmd_lo + 1;
			if (span > clpp_pkg::CMD_MAX - 1) begin
				span = clpp_pkg::CMD_MAX - 1;
				limit_hit = 1'b1;
			end
		end
		w.cmd_length = span[4:0];
		w.overflow = limit_hit;
		w.last = 1'b0;
		w.kind = clpp_pkg::KIND_HDR;
		w.value = tokens;
		expected_words.push_back(w);
		for (int unsigned k = 0; k < span; k++) begin
			w.kind = clpp_pkg::KIND_CHAR;
			w.value = 32'(text_at(cmd_lo + k));
			expected_words.push_back(w);
		end
		for (int unsigned t = 1; t < tokens; t++) begin
			w.kind = clpp_pkg::KIND_PARAM;
			w.value = number_of(t);
			expected_words.push_back(w);
		end
		expected_words[$].last = 1'b1;
		text_len = 0;
		limit_hit = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		clpp_pkg::out_t e;
		if (!arst_n) begin
			text_len = 0;
			limit_hit = 1'b0;
			tokens = 0;
			cmd_lo = 0;
			cmd_hi = 0;
			expected_words.delete();
			errors = 0;
			words_checked = 0;
		end else begin
			if (result_valid && result_ready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					$error("result word with none expected: %h", result_word);
					errors++;
				end else begin
					e = expected_words.pop_front();
					if (result_word.kind !== e.kind) begin
						$error("kind: expected %0d, got %0d", e.kind, result_word.kind);
						errors++;
					end
					if (result_word.value !== e.value) begin
						$error("value: expected %h, got %h", e.value, result_word.value);
						errors++;
					end
					if (result_word.cmd_length !== e.cmd_length) begin
						$error("cmd_length: expected %0d, got %0d", e.cmd_length,
							result_word.cmd_length);
						errors++;
					end
					if (result_word.overflow !== e.overflow) begin
						$error("overflow: expected %0b, got %0b", e.overflow,
							result_word.overflow);
						errors++;
					end
					if (result_word.last !== e.last) begin
						$error("last: expected %0b, got %0b", e.last, result_word.last);
						errors++;
					end
				end
			end
			if (line_valid && line_ready) begin
				if (text_len < clpp_pkg::LINE_MAX) begin
					text[text_len] = line_word.ch;
					text_len++;
				end else begin
					limit_hit = 1'b1;
				end
				if (line_word.end_of_line) tokenize_line();
			end
		end
	end

endmodule

### dv/command_line_param_parser_tb.sv
// Top of the command line parser bench: clock, reset, line stimulus, result sink and verdict.
`timescale 1ns / 1ps
module command_line_param_parser_tb;

	logic           clk = 0;
	logic           arst_n = 0;
	logic           line_valid = 0;
	logic           line_ready;
	clpp_pkg::in_t  line_word = '0;
	logic           result_valid;
	logic           result_ready = 0;
	clpp_pkg::out_t result_word;
	int             errors, pending, words_checked;
	int             lines_sent = 0;
	int             bytes_sent = 0;
	bit             sending_done = 0;
	logic [7:0]     line_q[$];

	always #10 clk = ~clk;

	command_line_param_parser u_top (.*);

	command_line_param_parser_checker u_checker (.*);

	task automatic send_line();
		int gap;
		foreach (line_q[i]) begin
			gap = $urandom_range(0, 17);
			if ($urandom_range(0, 3) == 0) gap = 0;
			if (gap > 0) begin
				line_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			line_valid <= 1'b1;
			line_word.ch <= line_q[i];
			line_word.end_of_line <= (i == line_q.size() - 1);
			do @(posedge clk); while (!line_ready);
			bytes_sent++;
		end
		lines_sent++;
		line_q.delete();
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
	endtask

	task automatic add_letters(int n);
		for (int i = 0; i < n; i++)
			line_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(65, 90))
				: 8'($urandom_range(97, 122)));
	endtask

	task automatic add_number();
		string hexd;
		hexd = "0123456789abcdefABCDEF";
		if ($urandom_range(0, 2) == 0) begin
			add_text($urandom_range(0, 1) ? "0x" : "0X");
			repeat ($urandom_range(1, 9)) line_q.push_back(hexd[$urandom_range(0, 21)]);
		end else begin
			repeat ($urandom_range(1, 11)) line_q.push_back(8'($urandom_range(48, 57)));
		end
	endtask

	task automatic build_random_line();
		int shape;
		shape = $urandom_range(0, 9);
		if (shape < 7) begin
			if ($urandom_range(0, 3) == 0) line_q.push_back(8'd32);
			add_letters((shape == 0) ? $urandom_range(28, 36) : $urandom_range(1, 8));
			repeat ((shape == 1) ? $urandom_range(9, 12) : $urandom_range(0, 5)) begin
				repeat ($urandom_range(1, 2)) line_q.push_back(8'd32);
				add_number();
			end
			if ($urandom_range(0, 4) == 0) line_q.push_back(8'($urandom_range(0, 255)));
			line_q.push_back(8'd10);
		end else if (shape == 7) begin
			add_text("a 1 ");
			add_letters($urandom_range(1, 4));
			add_text(" 0x");
			line_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 20)) line_q.push_back(8'($urandom_range(0, 255)));
			line_q.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		add_text("\n");
		send_line();
		add_text("add 0 4294967295 0x1F 0XfF 99999999999\n");
		send_line();
		add_text("AZaz 12 0xzz\n");
		send_line();
		add_text("5 go 7 stop 8 9\n");
		send_line();
		line_q.push_back(8'd0);
		add_text(" q 1");
		line_q.push_back(8'd255);
		add_text(" 0x");
		send_line();
		add_letters(40);
		add_text(" 1 2 3 4 5 6 7 8 9 10 11 12\n");
		send_line();
		add_text("z 3");
		repeat (140) line_q.push_back(8'd32);
		add_text("\n");
		send_line();
		while (bytes_sent < 420) begin
			build_random_line();
			send_line();
		end
		line_valid <= 1'b0;
		sending_done = 1;
	end

	initial begin
		int wait_n;
		int seen;
		seen = 0;
		@(posedge arst_n);
		forever begin
			wait_n = $urandom_range(0, 17);
			if ((seen / 40) % 3 == 2) wait_n = 0;
			if (seen == 12) wait_n = 600;
			if (wait_n > 0) begin
				result_ready <= 1'b0;
				repeat (wait_n) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			seen++;
		end
	end

	initial begin
		wait (sending_done);
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		$display("Sent %0d lines, %0d bytes; checked %0d result words.", lines_sent,
			bytes_sent, words_checked);
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#40ms;
		$display("Timed out with %0d result words outstanding.", pending);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
